@@ rtl/core/rcfp_pkg.sv @@
// Shared types, constants and helpers of the remote-control frame parser.
package rcfp_pkg;

   // Item kinds carried in the req_type field.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_ACK  = 1'b1;

   // Frame layout.
   localparam int unsigned FRAME_LEN    = 21;
   localparam int unsigned HDR_LEN      = 5;
   localparam int unsigned PAYLOAD_LEN  = 16;
   localparam int unsigned NUM_CHANNELS = 8;
   localparam int unsigned POS_W        = 5;
   localparam int unsigned IDX_W        = 4;

   localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(HDR_LEN);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LEN - 1);
   localparam logic [7:0]       START_RESET  = 8'h24;

   // Fixed header bytes that follow the start byte.
   localparam logic [7:0] HDR_B1 = 8'h4d;
   localparam logic [7:0] HDR_B2 = 8'h3c;
   localparam logic [7:0] HDR_B3 = 8'h10;
   localparam logic [7:0] HDR_B4 = 8'hc8;

   // Operation handed from the classifier to the payload stage.
   typedef struct packed {
      logic             payload_wr;
      logic             last;
      logic [IDX_W-1:0] index;
      logic [7:0]       data;
      logic             ready;
   } op_type;

   // Expected fixed header byte for header slot 0 to 3.
   function automatic logic [7:0] hdr_byte(input logic [1:0] slot);
      logic [7:0] value;
      unique case (slot)
         2'd0:    value = HDR_B1;
         2'd1:    value = HDR_B2;
         2'd2:    value = HDR_B3;
         default: value = HDR_B4;
      endcase
      return value;
   endfunction

endpackage

@@ rtl/core/rcfp_if.sv @@
// Channel interfaces of the remote-control frame parser.
interface rcfp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] byte_value;

   modport source (output valid, output req_type, output byte_value, input ready);
   modport sink   (input valid, input req_type, input byte_value, output ready);
endinterface

interface rcfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ready;
   logic        frame_done;
   logic [15:0] roll;
   logic [15:0] pitch;
   logic [15:0] yaw;
   logic [15:0] throttle;
   logic [15:0] aux_one;
   logic [15:0] aux_two;
   logic [15:0] aux_three;
   logic [15:0] aux_four;

   modport source (output valid, output frame_ready, output frame_done, output roll,
                   output pitch, output yaw, output throttle, output aux_one,
                   output aux_two, output aux_three, output aux_four, input ready);
   modport sink   (input valid, input frame_ready, input frame_done, input roll,
                   input pitch, input yaw, input throttle, input aux_one,
                   input aux_two, input aux_three, input aux_four, output ready);
endinterface

interface rcfp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] start_byte;

   modport source (output valid, output start_byte, input ready);
   modport sink   (input valid, input start_byte, output ready);
endinterface

@@ rtl/core/rcfp_front.sv @@
// Classifier: tracks the frame position and ready flag and emits one operation per beat.
module rcfp_front (
   input  logic                 clock,
   input  logic                 reset,
   rcfp_req_if.sink             req_chan,
   rcfp_csr_if.sink             csr_chan,
   input  logic                 op_full,
   output logic                 op_push,
   output rcfp_pkg::op_type     op_data
);

   logic [rcfp_pkg::POS_W-1:0] pos_ff;
   logic [rcfp_pkg::POS_W-1:0] pos_in;
   logic                       flag_ff;
   logic                       flag_in;
   logic [7:0]                 start_ff;
   logic [1:0]                 hdr_off;
   logic [rcfp_pkg::IDX_W-1:0] pay_off;

   assign req_chan.ready = !op_full;
   assign csr_chan.ready = 1'b1;
   assign op_push        = req_chan.valid && req_chan.ready;

   assign hdr_off = 2'(pos_ff - rcfp_pkg::POS_W'(1));
   assign pay_off = rcfp_pkg::IDX_W'(pos_ff - rcfp_pkg::POS_HDR_END);

   // Classify the incoming beat against the current frame position.
   always_comb begin
      pos_in             = pos_ff;
      flag_in            = flag_ff;
      op_data.payload_wr = 1'b0;
      op_data.last       = 1'b0;
      op_data.index      = pay_off;
      op_data.data       = req_chan.byte_value;
      if (req_chan.req_type == rcfp_pkg::REQ_ACK) begin
         flag_in = 1'b0;
      end else if (pos_ff == '0) begin
         if (!flag_ff && req_chan.byte_value == start_ff) begin
            pos_in = rcfp_pkg::POS_W'(1);
         end
      end else if (pos_ff < rcfp_pkg::POS_HDR_END) begin
         if (req_chan.byte_value == rcfp_pkg::hdr_byte(hdr_off)) begin
            pos_in = pos_ff + rcfp_pkg::POS_W'(1);
         end else begin
            pos_in = '0;
         end
      end else begin
         op_data.payload_wr = 1'b1;
         if (pos_ff >= rcfp_pkg::POS_LAST) begin
            op_data.last = 1'b1;
            pos_in       = '0;
            flag_in      = 1'b1;
         end else begin
            pos_in = pos_ff + rcfp_pkg::POS_W'(1);
         end
      end
      op_data.ready = flag_in;
   end

   // Position, flag and start byte registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         flag_ff  <= 1'b0;
         start_ff <= rcfp_pkg::START_RESET;
      end else begin
         if (op_push) begin
            pos_ff  <= pos_in;
            flag_ff <= flag_in;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            start_ff <= csr_chan.start_byte;
         end
      end
   end

endmodule

@@ rtl/core/rcfp_op_fifo.sv @@
// Two-entry queue of operations between the classifier and the payload stage.
module rcfp_op_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rcfp_pkg::op_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output rcfp_pkg::op_type pop_data
);

   rcfp_pkg::op_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/rcfp_back.sv @@
// Payload stage: stores payload bytes, composes channels and drives the result register.
module rcfp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  rcfp_pkg::op_type op_data,
   output logic             op_pop,
   rcfp_rsp_if.source       rsp_chan
);

   logic [7:0]  pay_ff   [rcfp_pkg::PAYLOAD_LEN];
   logic [7:0]  pay_next [rcfp_pkg::PAYLOAD_LEN];
   logic [15:0] chan_ff  [rcfp_pkg::NUM_CHANNELS];
   logic        rsp_valid_ff;
   logic        rsp_ready_ff;
   logic        rsp_done_ff;

   assign op_pop = op_valid && (!rsp_valid_ff || rsp_chan.ready);

   // Payload view with the current beat's byte merged in.
   always_comb begin
      for (int i = 0; i < rcfp_pkg::PAYLOAD_LEN; i++) begin
         pay_next[i] = pay_ff[i];
      end
      if (op_data.payload_wr) begin
         pay_next[op_data.index] = op_data.data;
      end
   end

   // Payload store, written one byte per beat.
   always_ff @(posedge clock) begin
      if (op_pop && op_data.payload_wr) begin
         pay_ff[op_data.index] <= op_data.data;
      end
   end

   // Channel latches and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_ready_ff <= 1'b0;
         rsp_done_ff  <= 1'b0;
         for (int k = 0; k < rcfp_pkg::NUM_CHANNELS; k++) begin
            chan_ff[k] <= '0;
         end
      end else begin
         if (op_pop) begin
            rsp_valid_ff <= 1'b1;
            rsp_ready_ff <= op_data.ready;
            rsp_done_ff  <= op_data.last;
            if (op_data.last) begin
               for (int k = 0; k < rcfp_pkg::NUM_CHANNELS; k++) begin
                  chan_ff[k] <= {pay_next[2*k+1], pay_next[2*k]};
               end
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_ready = rsp_ready_ff;
   assign rsp_chan.frame_done  = rsp_done_ff;
   assign rsp_chan.roll        = chan_ff[0];
   assign rsp_chan.pitch       = chan_ff[1];
   assign rsp_chan.yaw         = chan_ff[2];
   assign rsp_chan.throttle    = chan_ff[3];
   assign rsp_chan.aux_one     = chan_ff[4];
   assign rsp_chan.aux_two     = chan_ff[5];
   assign rsp_chan.aux_three   = chan_ff[6];
   assign rsp_chan.aux_four    = chan_ff[7];

endmodule

@@ rtl/core/rc_channel_frame_parser.sv @@
// Top level of the remote-control frame parser.
//
// The req channel carries one beat per received serial byte (req_type 0) or per
// acknowledge (req_type 1). The block hunts for a 21-byte frame: the start byte
// from the csr channel, four fixed header bytes and 16 payload bytes that form
// eight little-endian 16-bit channels. Every req beat yields exactly one rsp beat
// with the ready flag, a frame-done pulse and the channels of the last frame.
// The csr channel is always ready and writes the start byte.
// A classifier front end feeds a two-entry operation queue; the payload stage
// behind it writes the byte store and loads the result register. One beat is
// accepted per cycle while the queue is not full. An accepted req beat is
// written into the queue and then loads the result register, which presents it.
// When the rsp side stalls, the queue fills and req ready drops after two more
// beats; nothing is lost. Reset clears the position, the flag and the channels,
// and restores the start byte to 0x24; the block is ready in the next cycle.
module rc_channel_frame_parser (
   input  logic        clock,
   input  logic        reset,
   rcfp_req_if.sink    req_chan,
   rcfp_rsp_if.source  rsp_chan,
   rcfp_csr_if.sink    csr_chan
);

   logic             op_push;
   logic             op_full;
   logic             op_pop;
   logic             op_not_empty;
   rcfp_pkg::op_type op_in;
   rcfp_pkg::op_type op_out;

   rcfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .op_full  (op_full),
      .op_push  (op_push),
      .op_data  (op_in)
   );

   rcfp_op_fifo u_op_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .full      (op_full),
      .pop       (op_pop),
      .not_empty (op_not_empty),
      .pop_data  (op_out)
   );

   rcfp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_not_empty),
      .op_data  (op_out),
      .op_pop   (op_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
